/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define BWC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bwc: next-cycle check failed");

// Like BWC_ASSERT_NEXT, but with an added delay before the consequent is checked.
`define BWC_ASSERT_NEXT2(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error("bwc: two-cycle check failed");

`endif

/* rtl/bwc_pkg.sv */
// Package with sizes, character codes, types and helpers of the censor block.
`default_nettype none
package bwc_pkg;

  localparam int BANNED_SLOTS    = 16;
  localparam int WORD_BUFFER_LEN = 62;
  localparam int BANNED_MAX_LEN  = 8;

  localparam int BUF_AW  = $clog2(WORD_BUFFER_LEN);
  localparam int LEN_W   = $clog2(WORD_BUFFER_LEN + 1);
  localparam int SLOT_AW = $clog2(BANNED_SLOTS);
  localparam int CNT_W   = $clog2(BANNED_SLOTS + 1);
  localparam int HEAD_AW = $clog2(BANNED_MAX_LEN);

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam int         STAR_COUNT = 3;

  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MATCH = 7'b0000010,
    ST_STAR  = 7'b0000100,
    ST_WORD  = 7'b0001000,
    ST_SPACE = 7'b0010000,
    ST_NL    = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_e;

  // Write request into the banned-word table.
  typedef struct packed {
    logic        we;
    logic [3:0]  idx;
    logic [63:0] bytes;
    logic [3:0]  len;
  } slot_wr_t;

  typedef logic [BANNED_MAX_LEN-1:0][7:0] head_t;

  // Map ASCII A-Z to a-z, pass everything else.
  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/bwc_if.sv */
// Valid/ready stream interfaces for the input items and the output bytes.
`default_nettype none
interface bwc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  text_char;
  logic [3:0]  slot_index;
  logic [63:0] slot_bytes;
  logic [3:0]  slot_length;

  modport source (output valid, op, text_char, slot_index, slot_bytes, slot_length,
                  input ready);
  modport sink   (input valid, op, text_char, slot_index, slot_bytes, slot_length,
                  output ready);
endinterface

interface bwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface
`default_nettype wire

/* rtl/banned_word_censor_stream.sv */
// Top level of the banned-word censor: sequencer, head registers, output register, word buffer and match unit.
//
// Channels: in_i takes items (op 0 text byte, op 1 banned-table load); out_o
// gives result bytes with last set on the final byte caused by one item.
// cfg_we_i/cfg_data_i write banned_count (slots compared against each word).
// Flow: a load item or a plain word byte leaves the sequencer idle, so
// in_i.ready stays high. A space or newline steps the shared compare unit
// through each compared slot (min(banned_count, 16)), then emits each output
// byte ("***" or the word, the space, the newline). A word byte arriving with
// the 62-byte buffer full flushes the buffer at one byte a cycle while the
// receiver is ready. The byte rate is set by the single output register fed
// from the word buffer read port. Results wait in the output register while
// the receiver stalls; the sequencer holds and in_i.ready stays low until the
// item's last byte has been loaded. Reset clears the word length, the count
// and the output valid; the banned table is undefined until loaded.
`default_nettype none
module banned_word_censor_stream (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  bwc_in_if.sink         in_i,
  bwc_out_if.source      out_o,
  input  wire logic      cfg_we_i,
  input  wire logic [4:0] cfg_data_i
);

  bwc_pkg::state_e state_q, state_d;
  logic [bwc_pkg::LEN_W-1:0] word_len_q, word_len_d;
  logic [bwc_pkg::LEN_W-1:0] e_q, e_d;
  logic [bwc_pkg::CNT_W-1:0] s_q, s_d;
  logic                      hit_q, hit_d;
  logic                      nl_q, nl_d;
  logic [7:0]                pend_q, pend_d;
  logic [4:0]                count_q;
  bwc_pkg::head_t            head_q;
  logic                      out_valid_q;
  logic [7:0]                out_char_q;
  logic                      out_last_q;

  logic [bwc_pkg::CNT_W-1:0]   limit;
  logic                        accept;
  logic                        out_free;
  logic                        load_out;
  logic [7:0]                  out_char_n;
  logic                        out_last_n;
  logic                        ram_we;
  logic [bwc_pkg::BUF_AW-1:0]  ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [bwc_pkg::BUF_AW-1:0]  ram_raddr;
  logic [7:0]                  ram_rdata;
  logic                        head_we;
  logic [bwc_pkg::HEAD_AW-1:0] head_idx;
  logic [7:0]                  head_data;
  bwc_pkg::slot_wr_t           tbl_wr;
  logic                        match;

  assign in_i.ready = (state_q == bwc_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.last     = out_last_q;

  // Clamp the compared slot count to the table size.
  always_comb begin
    if (int'(count_q) > bwc_pkg::BANNED_SLOTS) begin
      limit = bwc_pkg::CNT_W'(bwc_pkg::BANNED_SLOTS);
    end else begin
      limit = bwc_pkg::CNT_W'(count_q);
    end
  end

  // Route load items to the table.
  always_comb begin
    tbl_wr.we    = accept && (in_i.op == bwc_pkg::OP_LOAD);
    tbl_wr.idx   = in_i.slot_index;
    tbl_wr.bytes = in_i.slot_bytes;
    tbl_wr.len   = in_i.slot_length;
  end

  // Read the next byte to be emitted.
  always_comb begin
    if (e_d < bwc_pkg::LEN_W'(bwc_pkg::WORD_BUFFER_LEN)) begin
      ram_raddr = e_d[bwc_pkg::BUF_AW-1:0];
    end else begin
      ram_raddr = '0;
    end
  end

  // Sequence buffering, slot compares and emission.
  always_comb begin
    state_d    = state_q;
    word_len_d = word_len_q;
    e_d        = e_q;
    s_d        = s_q;
    hit_d      = hit_q;
    nl_d       = nl_q;
    pend_d     = pend_q;
    load_out   = 1'b0;
    out_char_n = bwc_pkg::CH_SPACE;
    out_last_n = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = word_len_q[bwc_pkg::BUF_AW-1:0];
    ram_wdata  = in_i.text_char;
    head_we    = 1'b0;
    head_idx   = word_len_q[bwc_pkg::HEAD_AW-1:0];
    head_data  = in_i.text_char;

    case (state_q)
      bwc_pkg::ST_IDLE: begin
        if (accept && (in_i.op == bwc_pkg::OP_TEXT)) begin
          if ((in_i.text_char == bwc_pkg::CH_SPACE) ||
              (in_i.text_char == bwc_pkg::CH_NEWLINE)) begin
            nl_d    = (in_i.text_char == bwc_pkg::CH_NEWLINE);
            s_d     = '0;
            hit_d   = 1'b0;
            state_d = bwc_pkg::ST_MATCH;
          end else if (word_len_q >= bwc_pkg::LEN_W'(bwc_pkg::WORD_BUFFER_LEN)) begin
            pend_d  = in_i.text_char;
            e_d     = '0;
            state_d = bwc_pkg::ST_FLUSH;
          end else begin
            ram_we     = 1'b1;
            word_len_d = word_len_q + 1'b1;
            head_we    = (word_len_q < bwc_pkg::LEN_W'(bwc_pkg::BANNED_MAX_LEN));
          end
        end
      end
      bwc_pkg::ST_MATCH: begin
        if (s_q < limit) begin
          hit_d = hit_q | match;
          s_d   = s_q + 1'b1;
        end else begin
          e_d = '0;
          if (hit_q) begin
            state_d = bwc_pkg::ST_STAR;
          end else if (word_len_q == '0) begin
            state_d = bwc_pkg::ST_SPACE;
          end else begin
            state_d = bwc_pkg::ST_WORD;
          end
        end
      end
      bwc_pkg::ST_STAR: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_char_n = bwc_pkg::CH_STAR;
          e_d        = e_q + 1'b1;
          if (e_q == bwc_pkg::LEN_W'(bwc_pkg::STAR_COUNT - 1)) begin
            state_d = bwc_pkg::ST_SPACE;
          end
        end
      end
      bwc_pkg::ST_WORD: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_char_n = bwc_pkg::lower_ascii(ram_rdata);
          e_d        = e_q + 1'b1;
          if ((e_q + 1'b1) == word_len_q) begin
            state_d = bwc_pkg::ST_SPACE;
          end
        end
      end
      bwc_pkg::ST_SPACE: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_char_n = bwc_pkg::CH_SPACE;
          out_last_n = !nl_q;
          word_len_d = '0;
          state_d    = nl_q ? bwc_pkg::ST_NL : bwc_pkg::ST_IDLE;
        end
      end
      bwc_pkg::ST_NL: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_char_n = bwc_pkg::CH_NEWLINE;
          out_last_n = 1'b1;
          state_d    = bwc_pkg::ST_IDLE;
        end
      end
      bwc_pkg::ST_FLUSH: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_char_n = bwc_pkg::lower_ascii(ram_rdata);
          out_last_n = (e_q == bwc_pkg::LEN_W'(bwc_pkg::WORD_BUFFER_LEN - 1));
          e_d        = e_q + 1'b1;
          if (out_last_n) begin
            // Restart the buffer with the held byte.
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = pend_q;
            head_we    = 1'b1;
            head_idx   = '0;
            head_data  = pend_q;
            word_len_d = bwc_pkg::LEN_W'(1);
            state_d    = bwc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = bwc_pkg::ST_IDLE;
      end
    endcase
  end

  // Advance control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bwc_pkg::ST_IDLE;
      word_len_q  <= '0;
      e_q         <= '0;
      s_q         <= '0;
      hit_q       <= 1'b0;
      nl_q        <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      word_len_q <= word_len_d;
      e_q        <= e_d;
      s_q        <= s_d;
      hit_q      <= hit_d;
      nl_q       <= nl_d;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold payload: pending byte, word head, output byte.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (head_we) begin
      head_q[head_idx] <= head_data;
    end
    if (load_out) begin
      out_char_q <= out_char_n;
      out_last_q <= out_last_n;
    end
  end

  bwc_word_ram u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bwc_match_unit u_match_unit (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .sel_i      (s_q[bwc_pkg::SLOT_AW-1:0]),
    .head_i     (head_q),
    .word_len_i (word_len_q),
    .match_o    (match)
  );

endmodule
`default_nettype wire

/* rtl/bwc_word_ram.sv */
// Word buffer memory: one write port, one registered read port.
`default_nettype none
module bwc_word_ram (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [bwc_pkg::BUF_AW-1:0] waddr_i,
  input  wire logic [7:0]                 wdata_i,
  input  wire logic [bwc_pkg::BUF_AW-1:0] raddr_i,
  output logic      [7:0]                 rdata_o
);

  logic [7:0] mem [bwc_pkg::WORD_BUFFER_LEN];

  // Write one byte.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/bwc_match_unit.sv */
// Banned-word table and the shared compare unit that checks one slot per cycle.
`default_nettype none
module bwc_match_unit (
  input  wire logic                        clk_i,
  input  wire bwc_pkg::slot_wr_t           wr_i,
  input  wire logic [bwc_pkg::SLOT_AW-1:0] sel_i,
  input  wire bwc_pkg::head_t              head_i,
  input  wire logic [bwc_pkg::LEN_W-1:0]   word_len_i,
  output logic                             match_o
);

  logic [63:0] bytes_q [bwc_pkg::BANNED_SLOTS];
  logic [3:0]  len_q   [bwc_pkg::BANNED_SLOTS];
  logic [3:0]  wr_len;
  logic [63:0] sel_bytes;
  logic [3:0]  sel_len;

  // Saturate the slot length.
  always_comb begin
    if (wr_i.len > 4'(bwc_pkg::BANNED_MAX_LEN)) begin
      wr_len = 4'(bwc_pkg::BANNED_MAX_LEN);
    end else begin
      wr_len = wr_i.len;
    end
  end

  // Store a slot; drop indexes beyond the table.
  always_ff @(posedge clk_i) begin
    if (wr_i.we && (int'(wr_i.idx) < bwc_pkg::BANNED_SLOTS)) begin
      bytes_q[bwc_pkg::SLOT_AW'(wr_i.idx)] <= wr_i.bytes;
      len_q[bwc_pkg::SLOT_AW'(wr_i.idx)]   <= wr_len;
    end
  end

  assign sel_bytes = bytes_q[sel_i];
  assign sel_len   = len_q[sel_i];

  // Compare length and the valid characters, both lowercased.
  always_comb begin
    match_o = (bwc_pkg::LEN_W'(sel_len) == word_len_i);
    for (int i = 0; i < bwc_pkg::BANNED_MAX_LEN; i++) begin
      if ((i < int'(sel_len)) &&
          (bwc_pkg::lower_ascii(sel_bytes[8*i +: 8]) != bwc_pkg::lower_ascii(head_i[i]))) begin
        match_o = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bwc_checker.sv */
// Port-level checker for the censor block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module bwc_checker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bwc_in_if.sink     in_i,
  bwc_out_if.source  out_o
);

  logic in_acc;
  logic load_acc;
  logic delim_acc;

  assign in_acc    = in_i.valid && in_i.ready;
  assign load_acc  = in_acc && (in_i.op == bwc_pkg::OP_LOAD);
  assign delim_acc = in_acc && (in_i.op == bwc_pkg::OP_TEXT) &&
                     ((in_i.text_char == bwc_pkg::CH_SPACE) ||
                      (in_i.text_char == bwc_pkg::CH_NEWLINE));

  // A stalled result stays offered.
  `BWC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid)
  // A table load leaves the input ready again in the next cycle.
  `BWC_ASSERT_NEXT(a_load_ready, clk_i, rst_ni, load_acc, in_i.ready)
  // A word end keeps the input closed while slots are compared.
  `BWC_ASSERT_NEXT(a_delim_busy, clk_i, rst_ni, delim_acc, !in_i.ready)
  // A word end still keeps the input closed at the delayed check, with at least its space yet to emit.
  `BWC_ASSERT_NEXT2(a_delim_busy2, clk_i, rst_ni, delim_acc, !in_i.ready)

endmodule

bind banned_word_censor_stream bwc_checker u_bwc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
`default_nettype wire

/* tb/sv/bwc_tb_pkg.sv */
`timescale 1ns / 1ps
// Request and output byte types and the scoreboard of the censor testbench.
package bwc_tb_pkg;
  import bwc_pkg::*;

  typedef struct packed {
    logic        op;
    logic [7:0]  text_char;
    logic [3:0]  slot_index;
    logic [63:0] slot_bytes;
    logic [3:0]  slot_length;
  } censor_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } censor_byte_t;

  class censor_scoreboard;
    logic [7:0]   word_buf [WORD_BUFFER_LEN];
    int unsigned  word_len;
    logic [63:0]  slot_word [BANNED_SLOTS];
    int unsigned  slot_len [BANNED_SLOTS];
    int unsigned  compare_count;
    censor_byte_t byte_q [$];
    int unsigned  mismatches;

    function new();
      word_len      = 0;
      compare_count = 0;
      mismatches    = 0;
      foreach (slot_word[s]) begin
        slot_word[s] = '0;
        slot_len[s]  = 0;
      end
    endfunction

    // Fold ASCII A-Z down to a-z.
    function logic [7:0] fold_case(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
        return c + 8'h20;
      end
      return c;
    endfunction

    function void push_byte(logic [7:0] c);
      censor_byte_t b;
      b.out_char = c;
      b.last     = 1'b0;
      byte_q.push_back(b);
    endfunction

    // Compare the buffered word with one table slot, ignoring case.
    function bit slot_hit(int unsigned s);
      if (slot_len[s] != word_len) begin
        return 1'b0;
      end
      for (int unsigned i = 0; i < word_len; i++) begin
        if (fold_case(slot_word[s][8*i +: 8]) != fold_case(word_buf[i])) begin
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // End the word: stars on a hit, else the folded word, then the space.
    function void close_word();
      int unsigned span;
      bit          hit;
      span = (compare_count > BANNED_SLOTS) ? BANNED_SLOTS : compare_count;
      hit  = 1'b0;
      for (int unsigned s = 0; s < span; s++) begin
        if (slot_hit(s)) begin
          hit = 1'b1;
        end
      end
      if (hit) begin
        repeat (STAR_COUNT) push_byte(CH_STAR);
      end else begin
        for (int unsigned i = 0; i < word_len; i++) begin
          push_byte(fold_case(word_buf[i]));
        end
      end
      push_byte(CH_SPACE);
      word_len = 0;
    endfunction

    // Predict the bytes caused by one accepted request.
    function void note_request(censor_req_t r);
      int unsigned first;
      first = byte_q.size();
      if (r.op == OP_LOAD) begin
        if (r.slot_index < BANNED_SLOTS) begin
          slot_word[r.slot_index] = r.slot_bytes;
          slot_len[r.slot_index]  = (r.slot_length > BANNED_MAX_LEN) ?
                                    BANNED_MAX_LEN : r.slot_length;
        end
        return;
      end
      if (r.text_char == CH_SPACE) begin
        close_word();
      end else if (r.text_char == CH_NEWLINE) begin
        close_word();
        push_byte(CH_NEWLINE);
      end else begin
        // flush an overlong word uncensored and restart the buffer
        if (word_len >= WORD_BUFFER_LEN) begin
          for (int unsigned i = 0; i < WORD_BUFFER_LEN; i++) begin
            push_byte(fold_case(word_buf[i]));
          end
          word_len = 0;
        end
        word_buf[word_len] = r.text_char;
        word_len++;
      end
      if (byte_q.size() > first) begin
        byte_q[byte_q.size() - 1].last = 1'b1;
      end
    endfunction

    // Compare one output byte with the oldest prediction.
    function void check_result(censor_byte_t got);
      censor_byte_t want;
      if (byte_q.size() == 0) begin
        $error("out_char: expected none, actual %h (last %b)", got.out_char, got.last);
        mismatches++;
        return;
      end
      want = byte_q.pop_front();
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* tb/sv/banned_word_censor_stream_tb.sv */
`timescale 1ns / 1ps
// Top of the censor testbench: clock, reset, request driver, output checker and stimulus.
module banned_word_censor_stream_tb;
  import bwc_pkg::*;
  import bwc_tb_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int SEGMENTS      = 8;
  localparam int SEG_ITEMS     = 32;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_data;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  bwc_in_if  in_bus ();
  bwc_out_if out_bus ();

  censor_scoreboard sb;

  banned_word_censor_stream u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_bus),
    .out_o     (out_bus),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check output bytes and stall the output at random.
  initial begin
    censor_byte_t seen;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        seen.out_char = out_bus.out_char;
        seen.last     = out_bus.last;
        sb.check_result(seen);
      end
      out_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  // End the run when nothing moves for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[banned_word_censor_stream] ERROR");
    $finish;
  end

  // Offer one request, idling first at random, and hold it until accepted.
  task automatic send_request(censor_req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.op          <= r.op;
    in_bus.text_char   <= r.text_char;
    in_bus.slot_index  <= r.slot_index;
    in_bus.slot_bytes  <= r.slot_bytes;
    in_bus.slot_length <= r.slot_length;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_request(r);
    items_sent++;
  endtask

  // Text byte; the unused load fields carry noise.
  task automatic send_text(logic [7:0] c);
    censor_req_t r;
    r.op          = OP_TEXT;
    r.text_char   = c;
    r.slot_index  = 4'($urandom);
    r.slot_bytes  = {$urandom, $urandom};
    r.slot_length = 4'($urandom);
    send_request(r);
  endtask

  task automatic send_load(logic [3:0] idx, logic [63:0] bytes, logic [3:0] len);
    censor_req_t r;
    r.op          = OP_LOAD;
    r.text_char   = 8'($urandom);
    r.slot_index  = idx;
    r.slot_bytes  = bytes;
    r.slot_length = len;
    send_request(r);
  endtask

  // Drop valid and hold until every predicted byte has come out.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.byte_q.size() != 0) @(posedge clk);
  endtask

  // Write banned_count while the block is idle.
  task automatic write_count(logic [4:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.compare_count = v;
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(25));
    if ($urandom_range(3) == 0) begin
      c = c - 8'h20;
    end
    return c;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] pick_word_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (c == CH_SPACE || c == CH_NEWLINE);
    return c;
  endfunction

  function automatic logic [7:0] pick_delim();
    return ($urandom_range(3) == 0) ? CH_NEWLINE : CH_SPACE;
  endfunction

  function automatic logic [4:0] count_for_segment(int seg);
    case (seg)
      0: return 5'd17;
      1: return 5'd0;
      2: return 5'd31;
      3: return 5'd16;
      4: return 5'd1;
      5: return 5'($urandom_range(2, 15));
      6: return 5'd8;
      default: return 5'd16;
    endcase
  endfunction

  task automatic send_letters(int unsigned n);
    repeat (n) send_text(pick_letter());
  endtask

  // Send the word of a compared slot in random case, sometimes one byte short or long.
  task automatic send_banned_word();
    int unsigned span;
    int unsigned s;
    logic [7:0]  c;
    span = (sb.compare_count > BANNED_SLOTS) ? BANNED_SLOTS : sb.compare_count;
    if (span == 0) begin
      send_letters($urandom_range(1, 8));
      return;
    end
    s = $urandom_range(span - 1);
    for (int unsigned i = 0; i < sb.slot_len[s]; i++) begin
      c = sb.slot_word[s][8*i +: 8];
      if (c == CH_SPACE || c == CH_NEWLINE) begin
        c = pick_word_byte();
      end else if (is_letter(c) && $urandom_range(1) == 1) begin
        c = c ^ 8'h20;
      end
      if (!(i == sb.slot_len[s] - 1 && $urandom_range(5) == 0)) begin
        send_text(c);
      end
    end
    if ($urandom_range(5) == 0) begin
      send_text(pick_letter());
    end
  endtask

  // Load a random slot, mostly with a short letter word.
  task automatic send_random_load();
    logic [63:0] bytes;
    logic [3:0]  len;
    bytes = {$urandom, $urandom};
    len   = ($urandom_range(4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
    if ($urandom_range(9) < 7) begin
      for (int i = 0; i < 8 && i < len; i++) begin
        bytes[8*i +: 8] = pick_letter();
      end
    end
    send_load(4'($urandom), bytes, len);
  endtask

  // Load one given slot with a letter word of length 1 to 8.
  task automatic send_random_load_at(int s);
    logic [63:0] bytes;
    logic [3:0]  len;
    bytes = {$urandom, $urandom};
    len   = 4'($urandom_range(1, 8));
    for (int i = 0; i < len; i++) begin
      bytes[8*i +: 8] = pick_letter();
    end
    send_load(4'(s), bytes, len);
  endtask

  // One random unit of stimulus: mostly words with delimiters.
  task automatic send_unit();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_letters($urandom_range(1, 10));
      send_text(pick_delim());
    end else if (pick < 60) begin
      send_banned_word();
      send_text(pick_delim());
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 6)) send_text(pick_word_byte());
      send_text(pick_delim());
    end else if (pick < 80) begin
      send_random_load();
    end else if (pick < 88) begin
      send_text(pick_delim());
    end else if (pick < 89) begin
      send_letters($urandom_range(55, 70));
      send_text(pick_delim());
    end else if (pick < 92) begin
      drain_results();
    end else begin
      send_letters($urandom_range(1, 4));
      send_text(CH_SPACE);
      send_text(CH_SPACE);
    end
  endtask

  initial begin
    int unsigned seg_end;
    sb = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    in_bus.valid       = 1'b0;
    in_bus.op          = OP_TEXT;
    in_bus.text_char   = '0;
    in_bus.slot_index  = '0;
    in_bus.slot_bytes  = '0;
    in_bus.slot_length = '0;
    send_idle          = 33;
    recv_idle          = 83;
    items_sent         = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Word with no slot compared
    send_text(8'h48);
    send_text(8'h69);
    send_text(CH_SPACE);

    // Fill the whole table: empty slot, lowercase and uppercase words, all ones,
    // and a length that saturates
    send_load(4'd0, {$urandom, $urandom}, 4'd0);
    send_load(4'd1, {$urandom, 8'($urandom), 24'h646162}, 4'd3);
    send_load(4'd2, {$urandom, 8'($urandom), 24'h544143}, 4'd3);
    send_load(4'd3, '1, 4'd8);
    for (int s = 4; s < 15; s++) begin
      send_random_load_at(s);
    end
    send_load(4'd15, 64'h7a7a_7a7a_7a7a_7a7a, 4'd15);
    write_count(5'd16);

    // Uppercase hit, empty word hit, hit ended by newline, odd bytes in a word
    send_text(8'h42);
    send_text(8'h41);
    send_text(8'h44);
    send_text(CH_SPACE);
    send_text(CH_SPACE);
    send_text(8'h63);
    send_text(8'h61);
    send_text(8'h74);
    send_text(CH_NEWLINE);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h0D);
    send_text(CH_SPACE);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 3) begin
        send_idle = 83;
        recv_idle = 33;
      end else if (seg == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_count(count_for_segment(seg));
      // A word that exactly fills the buffer, and one that overflows it
      if (seg == 1) begin
        send_letters(WORD_BUFFER_LEN);
        send_text(CH_SPACE);
      end else if (seg == 4) begin
        send_letters(WORD_BUFFER_LEN + 2);
        send_text(CH_NEWLINE);
      end
      seg_end = items_sent + SEG_ITEMS;
      while (items_sent < seg_end) send_unit();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.byte_q.size() == 0) begin
      $display("[banned_word_censor_stream] OK");
    end else begin
      $display("[banned_word_censor_stream] ERROR");
    end
    $finish;
  end

endmodule
